// ----- rtl/lpu2u8_pkg.sv -----
// ----------------------------------------------------------------------------
// lpu2u8_pkg
// Shared types and constants for the length-prefixed UTF-16BE to UTF-8
// transcoder.
// ----------------------------------------------------------------------------
package lpu2u8_pkg;

  localparam int OUT_BUFFER_BYTES = 1024;
  localparam int BW_W             = $clog2(OUT_BUFFER_BYTES);
  localparam int MAX_RES          = 3;

  localparam logic [15:0] CP_2BYTE = 16'h0080;
  localparam logic [15:0] CP_3BYTE = 16'h0800;
  localparam logic [7:0]  LEAD_2B  = 8'hC0;
  localparam logic [7:0]  LEAD_3B  = 8'hE0;
  localparam logic [7:0]  CONT_B   = 8'h80;
  localparam logic [5:0]  CONT_MSK = 6'h3F;

  typedef enum logic [1:0] {
    KIND_TEXT    = 2'd0,
    KIND_END     = 2'd1,
    KIND_LEN_ERR = 2'd2
  } kind_t;

  typedef enum logic [3:0] {
    PH_LEN_HI  = 4'b0001,
    PH_LEN_LO  = 4'b0010,
    PH_UNIT_HI = 4'b0100,
    PH_UNIT_LO = 4'b1000
  } phase_t;

  typedef struct packed {
    logic [7:0] out_byte;
    kind_t      kind;
    logic       end_of_string;
    logic       last;
  } res_t;

  typedef struct packed {
    res_t [MAX_RES-1:0] r;
    logic [1:0]         n;
  } group_t;

endpackage

// ----- rtl/lpu2u8_emit.sv -----
// ----------------------------------------------------------------------------
// lpu2u8_emit
// Holds the results of one input word and sends them out one word a cycle while m_tready is high.
// ----------------------------------------------------------------------------
module lpu2u8_emit (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  lpu2u8_pkg::group_t  grp,
  output logic                ready,
  output logic                m_tvalid,
  input  logic                m_tready,
  output lpu2u8_pkg::res_t    head
);
  import lpu2u8_pkg::*;

  res_t [MAX_RES-1:0] buf_r;
  logic [1:0]         count;
  logic               pop;

  assign pop      = m_tvalid && m_tready;
  assign m_tvalid = (count != 2'd0);
  assign head     = buf_r[0];
  // room when empty or the final held word leaves this cycle
  assign ready    = (count == 2'd0) || (count == 2'd1 && m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else if (load) begin
      count <= grp.n;
    end else if (pop) begin
      count <= count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      buf_r <= grp.r;
    end else if (pop) begin
      buf_r[0] <= buf_r[1];
      buf_r[1] <= buf_r[2];
    end
  end

  a_load_room: assert property (@(posedge clk) disable iff (rst)
    load |-> (count == 2'd0 || (count == 2'd1 && pop)))
    else $error("group loaded over held results");

  a_single_last: assert property (@(posedge clk) disable iff (rst)
    (count == 2'd1) |-> head.last)
    else $error("final held word without last");

  a_eos_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && head.end_of_string) |-> head.last)
    else $error("end of string before last word of group");

  a_keep_going: assert property (@(posedge clk) disable iff (rst)
    (pop && count > 2'd1 && !load) |=> m_tvalid)
    else $error("held results dropped");

endmodule

// ----- rtl/length_prefixed_utf16be_to_utf8.sv -----
// ----------------------------------------------------------------------------
// length_prefixed_utf16be_to_utf8
// Parses a stream of 16-bit big-endian counts, each followed by that many
// UTF-16BE code units, and re-encodes the units as UTF-8 bytes.
// ----------------------------------------------------------------------------
// output: results of an input word appear in the cycle after it is accepted
// throughput: one input word a cycle; a unit low byte yields 0 to 3 output
//   words, one a cycle while m_tready is high; inputs stall as the buffer drains
// reset: synchronous, clears parse state and the result buffer, max_length 65535
module length_prefixed_utf16be_to_utf8 (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] byte_in
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [7:0] out_byte
  output logic [7:0]  m_tuser,   // [1:0] kind, [2] end_of_string, [7:3] zero
  output logic        m_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import lpu2u8_pkg::*;

  localparam logic [BW_W:0] BW_LIMIT = (BW_W+1)'(OUT_BUFFER_BYTES - 4);

  logic [15:0]     max_length;
  phase_t          phase, phase_next;
  logic [7:0]      length_high, length_high_next;
  logic [15:0]     units_left, units_left_next;
  logic [7:0]      pending_high, pending_high_next;
  logic [BW_W-1:0] bytes_written, bytes_written_next;
  logic            nul_seen, nul_seen_next;

  group_t      grp;
  res_t        head;
  logic        accept;
  logic        load;
  logic [15:0] len;
  logic [15:0] code;
  logic        emit_ok;

  // configuration port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {16'd0, max_length} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_length <= 16'hFFFF;
    end else if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
      max_length <= pwdata[15:0];
    end
  end

  assign accept = s_tvalid && s_tready;
  assign load   = accept && (grp.n != 2'd0);
  assign len    = {length_high, s_tdata};
  assign code   = {pending_high, s_tdata};
  assign emit_ok = (code != 16'd0) && !nul_seen &&
                   ({1'b0, bytes_written} < BW_LIMIT);

  always_comb begin
    phase_next         = phase;
    length_high_next   = length_high;
    units_left_next    = units_left;
    pending_high_next  = pending_high;
    bytes_written_next = bytes_written;
    nul_seen_next      = nul_seen;
    grp                = '0;

    unique case (phase)
      PH_LEN_HI: begin
        length_high_next = s_tdata;
        phase_next       = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        if (len > max_length) begin
          grp.r[0].kind          = KIND_LEN_ERR;
          grp.r[0].end_of_string = 1'b1;
          grp.n                  = 2'd1;
          phase_next             = PH_LEN_HI;
        end else if (len == 16'd0) begin
          grp.r[0].kind          = KIND_END;
          grp.r[0].end_of_string = 1'b1;
          grp.n                  = 2'd1;
          phase_next             = PH_LEN_HI;
        end else begin
          units_left_next    = len;
          bytes_written_next = '0;
          nul_seen_next      = 1'b0;
          phase_next         = PH_UNIT_HI;
        end
      end
      PH_UNIT_HI: begin
        pending_high_next = s_tdata;
        phase_next        = PH_UNIT_LO;
      end
      PH_UNIT_LO: begin
        units_left_next = units_left - 16'd1;
        if (code == 16'd0) begin
          nul_seen_next = 1'b1;
        end else if (emit_ok) begin
          if (code < CP_2BYTE) begin
            grp.r[0].out_byte = code[7:0];
            grp.n             = 2'd1;
          end else if (code < CP_3BYTE) begin
            grp.r[0].out_byte = LEAD_2B | {3'd0, code[10:6]};
            grp.r[1].out_byte = CONT_B | {2'd0, code[5:0] & CONT_MSK};
            grp.n             = 2'd2;
          end else begin
            grp.r[0].out_byte = LEAD_3B | {4'd0, code[15:12]};
            grp.r[1].out_byte = CONT_B | {2'd0, code[11:6] & CONT_MSK};
            grp.r[2].out_byte = CONT_B | {2'd0, code[5:0] & CONT_MSK};
            grp.n             = 2'd3;
          end
          bytes_written_next = bytes_written + BW_W'(grp.n);
        end
        if (units_left_next == 16'd0) begin
          // string done: mark final byte, or a bare end marker
          if (grp.n == 2'd0) begin
            grp.r[0].kind          = KIND_END;
            grp.r[0].end_of_string = 1'b1;
            grp.n                  = 2'd1;
          end else begin
            grp.r[grp.n - 2'd1].end_of_string = 1'b1;
          end
          phase_next = PH_LEN_HI;
        end else begin
          phase_next = PH_UNIT_HI;
        end
      end
      default: begin
        phase_next = PH_LEN_HI;
      end
    endcase

    if (grp.n != 2'd0) begin
      grp.r[grp.n - 2'd1].last = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_LEN_HI;
      length_high   <= 8'd0;
      units_left    <= 16'd0;
      pending_high  <= 8'd0;
      bytes_written <= '0;
      nul_seen      <= 1'b0;
    end else if (accept) begin
      phase         <= phase_next;
      length_high   <= length_high_next;
      units_left    <= units_left_next;
      pending_high  <= pending_high_next;
      bytes_written <= bytes_written_next;
      nul_seen      <= nul_seen_next;
    end
  end

  lpu2u8_emit u_emit (
    .clk      (clk),
    .rst      (rst),
    .load     (load),
    .grp      (grp),
    .ready    (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .head     (head)
  );

  assign m_tdata = head.out_byte;
  assign m_tuser = {5'd0, head.end_of_string, head.kind};
  assign m_tlast = head.last;

endmodule

// ----- tb/tb_length_prefixed_utf16be_to_utf8.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_length_prefixed_utf16be_to_utf8
// Drives length-prefixed UTF-16BE strings into the transcoder and checks every
// UTF-8 output word against an in-bench transcoder, under random stalls on
// both streams and across several max_length settings.
// ----------------------------------------------------------------------------
module tb_length_prefixed_utf16be_to_utf8;
  import lpu2u8_pkg::*;

  localparam logic [2:0] REG_MAX_LENGTH = 3'd0;

  logic        clk     = 1'b0;
  logic        rst     = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;   // [7:0] byte_in
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;           // [7:0] out_byte
  logic [7:0]  m_tuser;           // [1:0] kind, [2] end_of_string, [7:3] zero
  logic        m_tlast;
  logic        psel    = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite  = 1'b0;
  logic [2:0]  paddr   = 3'd0;
  logic [31:0] pwdata  = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  length_prefixed_utf16be_to_utf8 i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #2 clk = ~clk;

  logic [7:0] tx_bytes[$];
  res_t       utf8_expected[$];
  int         errors = 0;
  int         results_seen = 0;

  // transcoder state, mirrors the block
  phase_t      parse_phase = PH_LEN_HI;
  logic [7:0]  count_hi = 8'h00;
  logic [7:0]  unit_hi = 8'h00;
  int          units_remaining = 0;
  int          utf8_count = 0;
  bit          nul_hit = 1'b0;
  logic [15:0] limit_units = 16'hFFFF;

  function automatic res_t utf8_word(logic [7:0] b, kind_t k);
    res_t w;
    w.out_byte      = b;
    w.kind          = k;
    w.end_of_string = 1'b0;
    w.last          = 1'b0;
    return w;
  endfunction

  function automatic void transcode_byte(logic [7:0] b);
    res_t        words[$];
    logic [15:0] v;
    case (parse_phase)
      PH_LEN_HI: begin
        count_hi    = b;
        parse_phase = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        v = {count_hi, b};
        if (v > limit_units) begin
          words = {words, utf8_word(8'h00, KIND_LEN_ERR)};
          words[0].end_of_string = 1'b1;
          parse_phase = PH_LEN_HI;
        end else if (v == 16'd0) begin
          words = {words, utf8_word(8'h00, KIND_END)};
          words[0].end_of_string = 1'b1;
          parse_phase = PH_LEN_HI;
        end else begin
          units_remaining = int'(v);
          utf8_count      = 0;
          nul_hit         = 1'b0;
          parse_phase     = PH_UNIT_HI;
        end
      end
      PH_UNIT_HI: begin
        unit_hi     = b;
        parse_phase = PH_UNIT_LO;
      end
      default: begin
        v = {unit_hi, b};
        units_remaining--;
        if (v == 16'd0) begin
          nul_hit = 1'b1;
        end else if (!nul_hit && utf8_count + 4 < OUT_BUFFER_BYTES) begin
          if (v < CP_2BYTE) begin
            words = {words, utf8_word(v[7:0], KIND_TEXT)};
          end else if (v < CP_3BYTE) begin
            words = {words, utf8_word(LEAD_2B | {3'b000, v[10:6]}, KIND_TEXT)};
            words = {words, utf8_word(CONT_B | {2'b00, v[5:0] & CONT_MSK}, KIND_TEXT)};
          end else begin
            words = {words, utf8_word(LEAD_3B | {4'b0000, v[15:12]}, KIND_TEXT)};
            words = {words, utf8_word(CONT_B | {2'b00, v[11:6] & CONT_MSK}, KIND_TEXT)};
            words = {words, utf8_word(CONT_B | {2'b00, v[5:0] & CONT_MSK}, KIND_TEXT)};
          end
          utf8_count += words.size();
        end
        if (units_remaining == 0) begin
          // final unit with nothing to emit still closes the string
          if (words.size() == 0) words = {words, utf8_word(8'h00, KIND_END)};
          words[words.size()-1].end_of_string = 1'b1;
          parse_phase = PH_LEN_HI;
        end else begin
          parse_phase = PH_UNIT_HI;
        end
      end
    endcase
    if (words.size() != 0) words[words.size()-1].last = 1'b1;
    utf8_expected = {utf8_expected, words};
  endfunction

  function automatic int pick_pause();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // sender: one word in flight, gaps between words
  int gap = 0;
  bit tx_calm = 1'b0;

  always @(posedge clk) begin : driver
    if ($urandom_range(0, 99) == 0) tx_calm = !tx_calm;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (s_tvalid) transcode_byte(s_tdata);
      if (gap > 0) begin
        gap--;
        s_tvalid <= 1'b0;
      end else if (tx_bytes.size() != 0) begin
        s_tdata  <= tx_bytes.pop_front();
        s_tvalid <= 1'b1;
        gap = tx_calm ? 0 : pick_pause();
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  task automatic log_mismatch(input string what, input res_t want);
    errors++;
    if (errors <= 10)
      $display({"%0t %s: expected byte %02h kind %0d eos %0b last %0b,",
                " got byte %02h user %02h last %0b"},
               $time, what, want.out_byte, want.kind, want.end_of_string, want.last,
               m_tdata, m_tuser, m_tlast);
  endtask

  // receiver: checks words and stalls at random
  int hold = 0;
  int stall = 0;
  bit rx_calm = 1'b0;
  bit pressure_done = 1'b0;

  always @(posedge clk) begin : monitor
    res_t want;
    logic next_ready;
    if ($urandom_range(0, 99) == 0) rx_calm = !rx_calm;
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      if (utf8_expected.size() == 0) begin
        log_mismatch("unexpected word", utf8_word(8'h00, KIND_TEXT));
      end else begin
        want = utf8_expected.pop_front();
        if (m_tdata !== want.out_byte ||
            m_tuser !== {5'b00000, want.end_of_string, want.kind} ||
            m_tlast !== want.last)
          log_mismatch("mismatch", want);
      end
    end
    // long hold-off once while the sender keeps offering, so the block backs up
    if (!pressure_done && results_seen >= 30 && s_tvalid) begin
      hold = 400;
      pressure_done = 1'b1;
    end
    if (rst) begin
      next_ready = 1'b0;
    end else if (hold > 0) begin
      hold--;
      next_ready = 1'b0;
    end else if (stall > 0) begin
      stall--;
      next_ready = 1'b0;
    end else begin
      stall = rx_calm ? 0 : pick_pause();
      next_ready = (stall == 0);
    end
    m_tready <= next_ready;
  end

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == REG_MAX_LENGTH) limit_units = data[15:0];
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (tx_bytes.size() != 0 || s_tvalid || utf8_expected.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic push_word16(input logic [15:0] v);
    tx_bytes = {tx_bytes, v[15:8]};
    tx_bytes = {tx_bytes, v[7:0]};
  endtask

  function automatic logic [15:0] pick_unit(bit allow_nul);
    int r;
    r = $urandom_range(0, 99);
    if (allow_nul && r < 6) return 16'h0000;
    if (r < 35) return 16'($urandom_range(16'h0001, 16'h007F));
    if (r < 65) return 16'($urandom_range(16'h0080, 16'h07FF));
    return 16'($urandom_range(16'h0800, 16'hFFFF));
  endfunction

  function automatic int pick_len(int top);
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 0;
    if (r < 85) return $urandom_range(1, 8);
    return $urandom_range(9, top);
  endfunction

  // a count above the limit carries no units: the block goes back to the count
  task automatic queue_string(input int len);
    push_word16(len[15:0]);
    if (len != 0 && len <= limit_units)
      repeat (len) push_word16(pick_unit(1'b1));
  endtask

  initial begin : stimulus
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // full range, directed encodings and string ends
    apb_write(REG_MAX_LENGTH, 32'h0000_FFFF);
    push_word16(16'h0000);
    push_word16(16'd5);
    push_word16(16'h0041);
    push_word16(16'h007F);
    push_word16(16'h0080);
    push_word16(16'h07FF);
    push_word16(16'h0800);
    push_word16(16'd3);
    push_word16(16'hFFFF);
    push_word16(16'h0000);   // nul, the rest of the string is dropped
    push_word16(16'h0041);
    push_word16(16'd1);
    push_word16(16'h0000);
    repeat (6) queue_string(pick_len(24));
    wait_drained();

    // limit zero: every nonzero count is a length error
    apb_write(REG_MAX_LENGTH, 32'h0000_0000);
    push_word16(16'h0001);
    push_word16(16'hFFFF);
    push_word16(16'h0000);
    push_word16(16'h8000);
    repeat (15) push_word16(16'($urandom_range(0, 16'hFFFF)));
    wait_drained();

    // limit just below full range
    apb_write(REG_MAX_LENGTH, 32'h0000_FFFE);
    push_word16(16'hFFFF);
    repeat (4) queue_string(pick_len(24));
    wait_drained();

    // small random limit, counts straddle it
    apb_write(REG_MAX_LENGTH, $urandom_range(1, 6));
    repeat (12) queue_string($urandom_range(0, 10));
    wait_drained();

    repeat (20) @(posedge clk);
    if (errors == 0 && utf8_expected.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin : watchdog
    #3ms;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
